// ===== design/two_tank_pump_cycle_controller_macros.svh =====
// Assertion macros shared by the checker of the pump cycle controller.
// Each macro samples on the rising edge of clk and is disabled in reset.
`ifndef TWO_TANK_PUMP_CYCLE_CONTROLLER_MACROS_SVH
`define TWO_TANK_PUMP_CYCLE_CONTROLLER_MACROS_SVH

// Plain property, checked at every clock edge out of reset.
`define TPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication: the consequent must hold in the same cycle.
`define TPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent must hold in the following cycle.
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tpc_pkg.sv =====
// Shared types and constants of the two-tank pump cycle controller.
// Used by the configuration registers, the tick core and the top level.
package tpc_pkg;

    localparam int FP_W    = 16;
    localparam int CP_W    = 16;
    localparam int NEED_W  = 3;
    localparam int LIMIT_W = 22;
    localparam int SI_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [FP_W-1:0]    FLOAT_PERIOD_RST = 16'd200;
    localparam logic [CP_W-1:0]    CHECK_PERIOD_RST = 16'd100;
    localparam logic [NEED_W-1:0]  LOW_NEEDED_RST   = 3'd4;
    localparam logic [LIMIT_W-1:0] TANK2_LIMIT_RST  = 22'd1200000;
    localparam logic [SI_W-1:0]    RESEND_PERIOD_RST = 16'd200;

    localparam logic [7:0] ACK_START = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOAT_PERIOD  = 3'd0,
        REG_CHECK_PERIOD  = 3'd1,
        REG_LOW_NEEDED    = 3'd2,
        REG_TANK2_LIMIT   = 3'd3,
        REG_RESEND_PERIOD = 3'd4
    } tpc_reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_REMOTE    = 3'd1,
        PH_M3_FIRST  = 3'd2,
        PH_TANK2     = 3'd3,
        PH_M3_SECOND = 3'd4
    } tpc_phase_t;

    typedef struct packed {
        logic       float_level;
        logic       ut_level;
        logic       ack_valid;
        logic [7:0] ack_value;
    } tpc_in_t;

    typedef struct packed {
        logic       pump_m3_on;
        logic       tank2_valve_on;
        logic       send_strobe;
        logic       send_value;
        logic [2:0] cycle_phase;
        logic       emergency;
    } tpc_out_t;

    typedef struct packed {
        logic [FP_W-1:0]    float_period;
        logic [CP_W-1:0]    ut_check_period;
        logic [NEED_W-1:0]  ut_low_needed;
        logic [LIMIT_W-1:0] tank2_limit;
        logic [SI_W-1:0]    resend_period;
    } tpc_cfg_t;

endpackage

// ===== design/tpc_cfg_regs.sv =====
// Configuration register file of the pump cycle controller.
// Depends on tpc_pkg for the register indexes, widths and reset values.
module tpc_cfg_regs
    import tpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tpc_cfg_t              cfg
);

    tpc_cfg_t cfg_reg;
    tpc_cfg_t cfg_next;
    logic     wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index)
                REG_FLOAT_PERIOD:  cfg_next.float_period    = cfg_data[FP_W-1:0];
                REG_CHECK_PERIOD:  cfg_next.ut_check_period = cfg_data[CP_W-1:0];
                REG_LOW_NEEDED:    cfg_next.ut_low_needed   = cfg_data[NEED_W-1:0];
                REG_TANK2_LIMIT:   cfg_next.tank2_limit     = cfg_data[LIMIT_W-1:0];
                REG_RESEND_PERIOD: cfg_next.resend_period   = cfg_data[SI_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.float_period    <= FLOAT_PERIOD_RST;
            cfg_reg.ut_check_period <= CHECK_PERIOD_RST;
            cfg_reg.ut_low_needed   <= LOW_NEEDED_RST;
            cfg_reg.tank2_limit     <= TANK2_LIMIT_RST;
            cfg_reg.resend_period   <= RESEND_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/tpc_tick_core.sv =====
// Per-tick state and update logic of the pump cycle controller.
// Depends on tpc_pkg; one word is processed whenever step_en is high.
module tpc_tick_core
    import tpc_pkg::*;
#(
    parameter int UT_SAMPLES = 5
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step_en,
    input  tpc_in_t  item,
    input  tpc_cfg_t cfg,
    output tpc_out_t result
);

    localparam int CNT_W = $clog2(UT_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > NEED_W) ? CNT_W : NEED_W;

    tpc_phase_t             phase_reg, phase_next;
    logic                   level_full_reg, level_full_next;
    logic                   prior_level_reg, prior_level_next;
    logic [FP_W-1:0]        float_timer_reg, float_timer_next;
    logic [CP_W-1:0]        check_timer_reg, check_timer_next;
    logic [UT_SAMPLES-1:0]  ut_window_reg, ut_window_next;
    logic                   ut_sample_phase_reg;
    logic                   m3_drive_reg, m3_drive_next;
    logic                   tank2_drive_reg, tank2_drive_next;
    logic [LIMIT_W-1:0]     tank2_elapsed_reg, tank2_elapsed_next;
    logic                   request_bit_reg, request_bit_next;
    logic                   request_pending_reg, request_pending_next;
    logic                   ack_seen_reg, ack_seen_next;
    logic [SI_W-1:0]        send_timer_reg, send_timer_next;

    logic                   ack_hit;
    logic                   check_due;
    logic [CNT_W-1:0]       low_count;
    logic                   emerg;
    logic                   level_edge;
    logic                   ev_start_req, ev_valve_on, ev_m3_off, ev_stop_req, ev_valve_off;
    logic                   tank2_mid, valve_test, valve_timeout;
    logic                   pending_mid, ack_seen_mid;
    logic [SI_W-1:0]        send_timer_inc;
    logic                   strobe;

    assign ack_hit = item.ack_valid && (item.ack_value == ACK_START);

    // Float switch sample and period timer.
    assign level_full_next  = (float_timer_reg >= cfg.float_period) ? item.float_level
                                                                     : level_full_reg;
    assign float_timer_next = (float_timer_reg >= cfg.float_period) ? '0
                                                                     : float_timer_reg + 1'b1;

    // The under-tank window shifts on every second tick; a set bit marks low water.
    assign ut_window_next = ut_sample_phase_reg ? ut_window_reg
                          : {ut_window_reg[UT_SAMPLES-2:0], ~item.ut_level};

    always_comb
    begin
        low_count = '0;
        for (int i = 0; i < UT_SAMPLES; i++)
        begin
            low_count = low_count + CNT_W'(ut_window_next[i]);
        end
    end

    assign check_due        = check_timer_reg >= cfg.ut_check_period;
    assign check_timer_next = check_due ? '0 : check_timer_reg + 1'b1;
    assign emerg = check_due && (CMP_W'(low_count) >= CMP_W'(cfg.ut_low_needed));

    // Level edges move the cycle only on ticks without an emergency.
    assign level_edge   = !emerg && (level_full_next != prior_level_reg);
    assign ev_start_req = level_edge && !level_full_next && (phase_reg == PH_IDLE);
    assign ev_valve_on  = level_edge && !level_full_next && (phase_reg == PH_M3_FIRST);
    assign ev_m3_off    = level_edge && !level_full_next && (phase_reg == PH_M3_SECOND);
    assign ev_stop_req  = level_edge &&  level_full_next && (phase_reg == PH_REMOTE);
    assign ev_valve_off = level_edge &&  level_full_next && (phase_reg == PH_TANK2);

    // The runtime limit is not tested on the tick that opens the valve.
    assign tank2_mid     = ev_valve_on ? 1'b1 : (ev_valve_off ? 1'b0 : tank2_drive_reg);
    assign valve_test    = !emerg && tank2_mid && !ev_valve_on;
    assign valve_timeout = valve_test && (tank2_elapsed_reg >= cfg.tank2_limit);

    assign prior_level_next = level_edge ? level_full_next : prior_level_reg;

    // Cycle state.
    always_comb
    begin
        phase_next = phase_reg;
        if (emerg)
        begin
            phase_next = PH_IDLE;
        end
        else if (valve_timeout)
        begin
            phase_next = PH_M3_SECOND;
        end
        else if (level_edge)
        begin
            unique case (phase_reg)
                PH_IDLE:      if (!level_full_next) phase_next = PH_REMOTE;
                PH_REMOTE:    if (level_full_next)  phase_next = PH_M3_FIRST;
                PH_M3_FIRST:  if (!level_full_next) phase_next = PH_TANK2;
                PH_TANK2:     if (level_full_next)  phase_next = PH_M3_SECOND;
                PH_M3_SECOND: if (!level_full_next) phase_next = PH_IDLE;
                default:      phase_next = phase_reg;
            endcase
        end
    end

    // Drives, request handshake and transmit timer.
    always_comb
    begin
        if (emerg)
        begin
            m3_drive_next      = 1'b0;
            tank2_drive_next   = 1'b0;
            tank2_elapsed_next = '0;
        end
        else
        begin
            m3_drive_next = m3_drive_reg;
            if (ev_valve_on || ev_m3_off)
                m3_drive_next = 1'b0;
            if (ev_stop_req || ev_valve_off || valve_timeout)
                m3_drive_next = 1'b1;
            tank2_drive_next   = valve_timeout ? 1'b0 : tank2_mid;
            tank2_elapsed_next = ev_valve_on ? '0 : tank2_elapsed_reg;
            if (valve_test && !valve_timeout)
                tank2_elapsed_next = tank2_elapsed_reg + 1'b1;
        end

        pending_mid  = ack_hit ? 1'b0 : request_pending_reg;
        ack_seen_mid = ack_hit ? 1'b1 : ack_seen_reg;
        if (emerg || ev_start_req || ev_m3_off || ev_stop_req)
        begin
            request_bit_next     = !ev_stop_req;
            request_pending_next = 1'b1;
            ack_seen_next        = 1'b0;
        end
        else
        begin
            request_bit_next     = request_bit_reg;
            request_pending_next = pending_mid;
            ack_seen_next        = ack_seen_mid;
        end

        send_timer_inc  = (send_timer_reg == '1) ? send_timer_reg : send_timer_reg + 1'b1;
        strobe          = request_pending_next && !ack_seen_next
                          && (send_timer_inc >= cfg.resend_period);
        send_timer_next = strobe ? '0 : send_timer_inc;
    end

    always_comb
    begin
        result.pump_m3_on     = m3_drive_next;
        result.tank2_valve_on = tank2_drive_next;
        result.send_strobe    = strobe;
        result.send_value     = request_bit_next;
        result.cycle_phase    = phase_next;
        result.emergency      = emerg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            level_full_reg      <= 1'b0;
            prior_level_reg     <= 1'b1;
            float_timer_reg     <= '0;
            check_timer_reg     <= '0;
            ut_window_reg       <= '0;
            ut_sample_phase_reg <= 1'b0;
            m3_drive_reg        <= 1'b0;
            tank2_drive_reg     <= 1'b0;
            tank2_elapsed_reg   <= '0;
            request_bit_reg     <= 1'b0;
            request_pending_reg <= 1'b0;
            ack_seen_reg        <= 1'b0;
            send_timer_reg      <= '0;
        end
        else if (step_en)
        begin
            phase_reg           <= phase_next;
            level_full_reg      <= level_full_next;
            prior_level_reg     <= prior_level_next;
            float_timer_reg     <= float_timer_next;
            check_timer_reg     <= check_timer_next;
            ut_window_reg       <= ut_window_next;
            ut_sample_phase_reg <= ~ut_sample_phase_reg;
            m3_drive_reg        <= m3_drive_next;
            tank2_drive_reg     <= tank2_drive_next;
            tank2_elapsed_reg   <= tank2_elapsed_next;
            request_bit_reg     <= request_bit_next;
            request_pending_reg <= request_pending_next;
            ack_seen_reg        <= ack_seen_next;
            send_timer_reg      <= send_timer_next;
        end
    end

endmodule

// ===== design/two_tank_pump_cycle_controller.sv =====
// Channel   Handshake             Word
// in        in_valid / in_stall   in_word   (tpc_in_t, one tick)
// out       out_valid / out_stall out_word  (tpc_out_t, one result per tick)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each tick word is held in an input register, processed combinationally by the tick core
// and written to the output register, so one word is taken every cycle while the output
// is not stalled. An accepted word moves from the input register to the output register,
// where its result shows on out_valid and can be taken. The block stalls its input only
// while a word waits in the input register and the output register is full and stalled.
// Reset clears all state but the word registers at once; no clearing pass.
// Top level of the pump cycle controller; depends on tpc_pkg, tpc_cfg_regs, tpc_tick_core.
module two_tank_pump_cycle_controller
    import tpc_pkg::*;
#(
    parameter int UT_SAMPLES = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tpc_in_t               in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tpc_out_t              out_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tpc_cfg_t cfg;
    tpc_out_t result;

    logic     in_valid_reg, in_valid_next;
    tpc_in_t  in_word_reg;
    logic     out_valid_reg, out_valid_next;
    tpc_out_t out_word_reg;
    logic     advance;
    logic     in_take;

    tpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpc_tick_core #(
        .UT_SAMPLES (UT_SAMPLES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_word_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_word_reg <= in_word;
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== design/tpc_checker.sv =====
// Port-level checker for the pump cycle controller, bound to the top level.
// Depends on tpc_pkg and the assertion macros header.
`include "two_tank_pump_cycle_controller_macros.svh"

module tpc_checker
    import tpc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input tpc_out_t out_word
);

    // A stalled result word must stay in place.
    `TPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_word), "stalled output word changed")

    // The input only stalls behind a full, stalled output register.
    `TPC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without output back-pressure")

    // Pump M3 and the tank2 valve never run together.
    `TPC_ASSERT(a_drive_excl,
        !(out_valid && out_word.pump_m3_on && out_word.tank2_valve_on),
        "pump M3 and tank2 valve both on")

    // An emergency stops both drives and returns the cycle to its first state.
    `TPC_ASSERT_IMP(a_emerg_stop, out_valid && out_word.emergency,
        !out_word.pump_m3_on && !out_word.tank2_valve_on && (out_word.cycle_phase == PH_IDLE),
        "emergency left drives or phase active")

    // The cycle phase stays within its five states.
    `TPC_ASSERT_IMP(a_phase_range, out_valid, out_word.cycle_phase <= PH_M3_SECOND,
        "cycle phase out of range")

endmodule

bind two_tank_pump_cycle_controller tpc_checker u_tpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
